[rtl/hpp_pkg.sv]
// shared types and constants for the helix phase block
// no dependencies
`default_nettype none

package hpp_pkg;

    localparam int CfgAddrBits = 2;

    localparam logic [CfgAddrBits-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CfgAddrBits-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CfgAddrBits-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CfgAddrBits-1:0] CFG_PITCH    = 2'd3;

    localparam int PhaseWidth = 48;
    localparam int AccBits    = 32;
    localparam int CordicBits = 64;

    // control that moves with each word along the chain
    typedef struct packed {
        logic valid;
        logic on_axis;
        logic neg_q;
    } cell_ctl_t;

    // atan(2^-i) in turns, 2^32 per turn
    function automatic logic [AccBits-1:0] atan_turns(input logic [4:0] i);
        logic [AccBits-1:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/hpp_cell.sv]
// one cell of the chain: one cordic vectoring step and one restoring divide step, each switched on by its parameter
// depends on hpp_pkg
`default_nettype none

module hpp_cell
    import hpp_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int RW        = 25,
    parameter int NB        = 42,
    parameter bit CORDIC_ON = 1'b1,
    parameter bit DIV_ON    = 1'b1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic [RW-1:0]                den,
    input  wire cell_ctl_t                    ctl_in,
    input  wire logic signed [CordicBits-1:0] x_in,
    input  wire logic signed [CordicBits-1:0] y_in,
    input  wire logic [AccBits-1:0]           acc_in,
    input  wire logic [RW+NB-1:0]             rq_in,
    output cell_ctl_t                         ctl_out,
    output logic signed [CordicBits-1:0]      x_out,
    output logic signed [CordicBits-1:0]      y_out,
    output logic [AccBits-1:0]                acc_out,
    output logic [RW+NB-1:0]                  rq_out
);

    cell_ctl_t                    ctl_reg;
    logic signed [CordicBits-1:0] x_reg, y_reg, x_next, y_next;
    logic [AccBits-1:0]           acc_reg, acc_next;
    logic [RW+NB-1:0]             rq_reg, rq_next;

    generate
        if (CORDIC_ON) begin : g_cordic
            logic [AccBits-1:0] ang;
            assign ang = atan_turns(5'(IDX));
            always_comb begin
                if (!y_in[CordicBits-1]) begin
                    x_next   = x_in + (y_in >>> IDX);
                    y_next   = y_in - (x_in >>> IDX);
                    acc_next = acc_in + ang;
                end else begin
                    x_next   = x_in - (y_in >>> IDX);
                    y_next   = y_in + (x_in >>> IDX);
                    acc_next = acc_in - ang;
                end
            end
        end else begin : g_nocordic
            assign x_next   = x_in;
            assign y_next   = y_in;
            assign acc_next = acc_in;
        end

        if (DIV_ON) begin : g_div
            logic [RW+NB-1:0] sh;
            logic [RW-1:0]    top;
            always_comb begin
                sh  = rq_in << 1;
                top = sh[RW+NB-1:NB];
                rq_next = sh;
                if (top >= den) begin
                    rq_next[RW+NB-1:NB] = top - den;
                    rq_next[0]          = 1'b1;
                end
            end
        end else begin : g_nodiv
            assign rq_next = rq_in;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
            rq_reg  <= rq_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign acc_out = acc_reg;
    assign rq_out  = rq_reg;

endmodule

`default_nettype wire

[rtl/hpp_unwrap.sv]
// azimuth rounding, turn unwrap from height, saturation and output register
// depends on hpp_pkg
`default_nettype none

module hpp_unwrap
    import hpp_pkg::*;
#(
    parameter int F  = 16,
    parameter int NB = 42
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  pitch_nz,
    input  wire cell_ctl_t             ctl_in,
    input  wire logic [AccBits-1:0]    acc_in,
    input  wire logic [NB-1:0]         q_in,
    output logic                       out_valid,
    output logic [PhaseWidth-1:0]      out_phase,
    output logic                       out_unwrapped
);

    localparam int W  = NB + 4;
    localparam int SW = (W > PhaseWidth + 1) ? W : PhaseWidth + 1;

    localparam logic signed [W-1:0]  ONE  = W'(1) << F;
    localparam logic signed [W-1:0]  HALF = W'(1) << (F - 1);
    localparam logic signed [W-1:0]  FMSK = ONE - W'(1);
    localparam logic signed [SW-1:0] TMAX =
        {{(SW-PhaseWidth+1){1'b0}}, {(PhaseWidth-1){1'b1}}};
    localparam logic signed [SW-1:0] TMIN = ~TMAX;

    // stage a
    logic [AccBits:0]    rnd;
    logic [F:0]          araw;
    logic [F-1:0]        az;
    logic signed [W-1:0] tz, lo_next, hi_next;

    logic                va_reg, pnz_reg;
    logic [F-1:0]        az_reg;
    logic signed [W-1:0] lo_reg, hi_reg;

    always_comb begin
        rnd  = {1'b0, acc_in} + ((AccBits+1)'(1) << (31 - F));
        araw = rnd[AccBits:AccBits-F];
        // a full turn wraps to zero, as does a point on the axis
        az   = (ctl_in.on_axis || araw[F]) ? '0 : araw[F-1:0];
        tz   = ctl_in.neg_q ? -W'(q_in) : W'(q_in);
        lo_next = tz - HALF - W'(az);
        hi_next = W'(az) - tz - HALF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pnz_reg <= pitch_nz;
            az_reg  <= az;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
        end
    end

    // stage b
    logic signed [W-1:0]  t;
    logic signed [SW-1:0] ts;
    logic [PhaseWidth-1:0] ph_next;

    always_comb begin
        t = W'(az_reg);
        if (pnz_reg) begin
            if (lo_reg > 0) begin
                t = W'(az_reg) + ((lo_reg + FMSK) & ~FMSK);
            end else if (hi_reg > 0) begin
                t = W'(az_reg) - ((hi_reg + FMSK) & ~FMSK);
            end
        end
        ts = SW'(t);
        if (ts > TMAX) begin
            ph_next = TMAX[PhaseWidth-1:0];
        end else if (ts < TMIN) begin
            ph_next = TMIN[PhaseWidth-1:0];
        end else begin
            ph_next = ts[PhaseWidth-1:0];
        end
    end

    logic                  ov_reg, unw_reg;
    logic [PhaseWidth-1:0] ph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg  <= ph_next;
            unw_reg <= pnz_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign out_phase     = ph_reg;
    assign out_unwrapped = unw_reg;

endmodule

`default_nettype wire

[rtl/helix_parameter_from_point.sv]
// top level: input register, chain of cordic/divide cells, unwrap and output stage
// depends on hpp_pkg, hpp_cell, hpp_unwrap
`default_nettype none

// Maps a point (x, y, z) to the helix phase in turns with PHASE_FRAC_BITS
// fraction bits. One word is taken every cycle while the result side does
// not stall, and results come out in order, through the input register,
// the row of cells that runs the cordic rotations and the restoring divide
// for the height turn, and the unwrap stage with its output register. A
// stall on the result side holds the whole row. Configuration is to be
// written only while no word is inside; the block does not enforce this.
module helix_parameter_from_point
    import hpp_pkg::*;
#(
    parameter int COORD_BITS      = 24,
    parameter int PHASE_FRAC_BITS = 16,
    parameter int CORDIC_STAGES   = 20
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CfgAddrBits-1:0]        cfg_addr,
    input  wire logic [COORD_BITS-1:0]         cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // point_x, point_y, point_z
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // phase
    output logic [PhaseWidth-1:0]              m_tdata,
    // z_unwrapped
    output logic [0:0]                         m_tuser
);

    localparam int CB    = COORD_BITS;
    localparam int F     = PHASE_FRAC_BITS;
    localparam int RW    = CB + 1;
    localparam int NB    = CB + F + 2;
    localparam int CHAIN = (CORDIC_STAGES > NB) ? CORDIC_STAGES : NB;
    localparam int PRE   = 60 - CB;

    logic signed [CB-1:0] cx_reg, cy_reg, cz_reg, pitch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            pitch_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_CENTER_X: cx_reg    <= cfg_wr_data;
                CFG_CENTER_Y: cy_reg    <= cfg_wr_data;
                CFG_CENTER_Z: cz_reg    <= cfg_wr_data;
                CFG_PITCH:    pitch_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input stage
    logic signed [CB-1:0]         px, py, pz;
    logic signed [RW-1:0]         dx, dy, dz;
    logic signed [CordicBits-1:0] xs, ys, x0, y0;
    logic [RW-1:0]                adz, den;
    logic [NB-1:0]                num;
    cell_ctl_t                    ctl0;

    always_comb begin
        px  = s_tdata[CB-1:0];
        py  = s_tdata[2*CB-1:CB];
        pz  = s_tdata[3*CB-1:2*CB];
        dx  = RW'(px) - RW'(cx_reg);
        dy  = RW'(py) - RW'(cy_reg);
        dz  = RW'(pz) - RW'(cz_reg);
        xs  = CordicBits'(dx) <<< PRE;
        ys  = CordicBits'(dy) <<< PRE;
        x0  = dx[RW-1] ? -xs : xs;
        y0  = dx[RW-1] ? -ys : ys;
        adz = dz[RW-1] ? -dz : dz;
        num = (NB'(adz) << F) + NB'(den >> 1);
        ctl0.valid   = s_tvalid;
        ctl0.on_axis = (dx == '0) && (dy == '0);
        ctl0.neg_q   = dz[RW-1] ^ pitch_reg[CB-1];
    end

    assign den = pitch_reg[CB-1] ? -RW'(pitch_reg) : RW'(pitch_reg);

    cell_ctl_t                    ctl_c [CHAIN+1];
    logic signed [CordicBits-1:0] x_c   [CHAIN+1];
    logic signed [CordicBits-1:0] y_c   [CHAIN+1];
    logic [AccBits-1:0]           acc_c [CHAIN+1];
    logic [RW+NB-1:0]             rq_c  [CHAIN+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_c[0] <= '0;
        end else if (en) begin
            ctl_c[0] <= ctl0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_c[0]   <= x0;
            y_c[0]   <= y0;
            acc_c[0] <= dx[RW-1] ? {1'b1, {(AccBits-1){1'b0}}} : '0;
            rq_c[0]  <= {{RW{1'b0}}, num};
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CHAIN; gi++) begin : g_cell
            hpp_cell #(
                .IDX       (gi),
                .RW        (RW),
                .NB        (NB),
                .CORDIC_ON (gi < CORDIC_STAGES),
                .DIV_ON    (gi < NB)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .den     (den),
                .ctl_in  (ctl_c[gi]),
                .x_in    (x_c[gi]),
                .y_in    (y_c[gi]),
                .acc_in  (acc_c[gi]),
                .rq_in   (rq_c[gi]),
                .ctl_out (ctl_c[gi+1]),
                .x_out   (x_c[gi+1]),
                .y_out   (y_c[gi+1]),
                .acc_out (acc_c[gi+1]),
                .rq_out  (rq_c[gi+1])
            );
        end
    endgenerate

    hpp_unwrap #(
        .F  (F),
        .NB (NB)
    ) u_unwrap (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .pitch_nz      (pitch_reg != '0),
        .ctl_in        (ctl_c[CHAIN]),
        .acc_in        (acc_c[CHAIN]),
        .q_in          (rq_c[CHAIN][NB-1:0]),
        .out_valid     (m_tvalid),
        .out_phase     (m_tdata),
        .out_unwrapped (m_tuser[0])
    );

endmodule

`default_nettype wire

[rtl/hpp_checker.sv]
// port-level checks on the helix phase block, bound to the top level
// depends on hpp_pkg and helix_parameter_from_point
`default_nettype none

module hpp_checker
    import hpp_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 16
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [PhaseWidth-1:0] m_tdata,
    input wire logic [0:0]            m_tuser
);

    // a held result keeps its word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // the row advances exactly when the result slot frees
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output slot");

    // without a pitch the phase is a plain azimuth in [0, 1) turns
    a_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[PhaseWidth-1:PHASE_FRAC_BITS] == '0)
        else $error("flat azimuth out of range");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind helix_parameter_from_point hpp_checker #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
) u_hpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
